// ----- design/lr_pkg.sv -----
// lr_pkg: shared constants and controller/datapath interface types
// for the line rasterizer; no dependencies
package lr_pkg;

  localparam int COORD_BITS_DEF = 10;

  // item kinds carried on the input tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture endpoints, signs and deltas
    logic setup;  // pick major axis, set error term and pixel count
    logic step;   // emit current pixel into the output register and advance
  } lr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pixels_zero;  // no pixels left, line finished or never loaded
  } lr_status_t;

endpackage

// ----- design/lr_ctrl.sv -----
// lr_ctrl: controller state machine for the line rasterizer, handles both
// stream handshakes and issues commands; depends on lr_pkg
module lr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lr_pkg::lr_status_t status,
  output lr_pkg::lr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SETUP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  // in run state, and output register free or being drained this cycle
  assign in_ready = (state == ST_RUN) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load  = accept && (in_kind == lr_pkg::KIND_LOAD);
    cmd.setup = (state == ST_SETUP);
    // a step with nothing left to draw is consumed silently
    cmd.step  = accept && (in_kind == lr_pkg::KIND_STEP) && !status.pixels_zero;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (cmd.load) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/lr_datapath.sv -----
// lr_datapath: line state registers, delta and error arithmetic and the
// output pixel register; depends on lr_pkg
module lr_datapath #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lr_pkg::lr_cmd_t       cmd,
  output lr_pkg::lr_status_t    status,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  localparam int ERR_BITS = COORD_BITS + 2;

  logic [COORD_BITS-1:0]      cur_x;
  logic [COORD_BITS-1:0]      cur_y;
  logic signed [ERR_BITS-1:0] error_term;
  logic [COORD_BITS-1:0]      major_delta;
  logic [COORD_BITS-1:0]      minor_delta;
  logic                       steep_flag;
  logic                       step_x_neg;
  logic                       step_y_neg;
  logic [COORD_BITS-1:0]      pixels_left;
  logic [COORD_BITS-1:0]      dx;
  logic [COORD_BITS-1:0]      dy;

  // load stage: absolute deltas and step signs
  logic                       x_up;
  logic                       y_up;
  logic [COORD_BITS-1:0]      dx_next;
  logic [COORD_BITS-1:0]      dy_next;

  // setup stage: both error candidates, selected by the steep compare
  logic                       steep_next;
  logic signed [ERR_BITS-1:0] err_flat;
  logic signed [ERR_BITS-1:0] err_steep;
  logic signed [ERR_BITS-1:0] dx_ext;
  logic signed [ERR_BITS-1:0] dy_ext;

  // step stage
  logic signed [ERR_BITS-1:0] minor_ext;
  logic signed [ERR_BITS-1:0] major_ext;
  logic signed [ERR_BITS-1:0] error_next;
  logic [COORD_BITS-1:0]      x_stepped;
  logic [COORD_BITS-1:0]      y_stepped;
  logic                       minor_move;

  assign x_up    = x_end > x_start;
  assign y_up    = y_end > y_start;
  assign dx_next = x_up ? (x_end - x_start) : (x_start - x_end);
  assign dy_next = y_up ? (y_end - y_start) : (y_start - y_end);

  assign dx_ext     = ERR_BITS'(dx);
  assign dy_ext     = ERR_BITS'(dy);
  assign steep_next = dy > dx;
  assign err_flat   = (dy_ext <<< 1) - dx_ext;
  assign err_steep  = (dx_ext <<< 1) - dy_ext;

  assign minor_ext  = ERR_BITS'(minor_delta);
  assign major_ext  = ERR_BITS'(major_delta);
  assign minor_move = !error_term[ERR_BITS-1];
  assign error_next = minor_move
                      ? error_term + (minor_ext <<< 1) - (major_ext <<< 1)
                      : error_term + (minor_ext <<< 1);
  assign x_stepped  = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
  assign y_stepped  = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;

  assign status.pixels_zero = (pixels_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      error_term  <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      steep_flag  <= 1'b0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      pixels_left <= '0;
      dx          <= '0;
      dy          <= '0;
    end else if (cmd.load) begin
      cur_x      <= x_start;
      cur_y      <= y_start;
      step_x_neg <= !x_up;
      step_y_neg <= !y_up;
      dx         <= dx_next;
      dy         <= dy_next;
      // a new line drops whatever was still being drawn
      pixels_left <= '0;
    end else if (cmd.setup) begin
      steep_flag  <= steep_next;
      major_delta <= steep_next ? dy : dx;
      minor_delta <= steep_next ? dx : dy;
      error_term  <= steep_next ? err_steep : err_flat;
      pixels_left <= steep_next ? dy : dx;
    end else if (cmd.step) begin
      error_term  <= error_next;
      pixels_left <= pixels_left - 1'b1;
      if (minor_move) begin
        cur_x <= x_stepped;
        cur_y <= y_stepped;
      end else if (steep_flag) begin
        cur_y <= y_stepped;
      end else begin
        cur_x <= x_stepped;
      end
    end
  end

  // output pixel register, held until the receiver takes it
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x    <= cur_x;
      pixel_y    <= cur_y;
      last_pixel <= (pixels_left == COORD_BITS'(1));
    end
  end

endmodule

// ----- design/line_rasterizer.sv -----
// line_rasterizer: Bresenham line generator for all octants, top level
// joining controller and datapath; depends on lr_pkg, lr_ctrl, lr_datapath
//
// usage: the input stream carries items; tuser selects the kind. a load
// transaction (tuser 0) takes both endpoints from tdata and starts a new
// line, dropping any line in progress. a step transaction (tuser 1) emits
// the current pixel on the output stream and advances it; the final pixel
// of a line has tlast set. steps with no line in progress emit nothing.
// the end point is not drawn, so a line of major length n gives n pixels.
// throughput: one step per clock when the output register is not stalled;
// a load captures deltas, then, with tready low, does axis selection and
// error setup. a pixel appears on the output in the cycle after its step.
// the single output register is the only buffer: while it holds a pixel
// the receiver has not taken, tready drops and the input stalls.
// reset clears the line state, so steps after reset produce nothing.
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // x_start, y_start, x_end, y_end from the lowest bit up, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // kind
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // pixel_x, pixel_y from the lowest bit up, zero padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // last_pixel
  output logic                                    m_axis_tlast
);

  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  lr_pkg::lr_cmd_t       cmd;
  lr_pkg::lr_status_t    status;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .x_start    (s_axis_tdata[COORD_BITS-1:0]),
    .y_start    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .x_end      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .y_end      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule
